FILE: src/ps2kb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2kb_pkg
// Types and protocol constants for the PS/2 keyboard command sequencer.
// ----------------------------------------------------------------------------
package ps2kb_pkg;

    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_RX      = 2'd1;
    localparam logic [1:0] REQ_TX      = 2'd2;

    localparam logic [7:0] BYTE_ACK       = 8'hFA;
    localparam logic [7:0] BYTE_RESEND    = 8'hFE;
    localparam logic [7:0] CMD_RESET      = 8'hFF;
    localparam logic [7:0] SELF_TEST_PASS = 8'hAA;
    localparam logic [7:0] BYTE_ECHO      = 8'hEE;
    localparam logic [7:0] BYTE_RESTART   = 8'h00;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] cmd_byte;
        logic [7:0] param_byte;
        logic       has_param;
        logic       expects_extra;
        logic [7:0] rx_byte;
    } ps2kb_req_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       done_valid;
        logic       done_status;
        logic [7:0] extra_response;
        logic       key_valid;
        logic [7:0] key_byte;
        logic       enqueue_rejected;
        logic [3:0] queue_count;
    } ps2kb_res_t;

    // one queued command as held in the command RAM
    typedef struct packed {
        logic       expects_extra;
        logic       has_param;
        logic [7:0] param_byte;
        logic [7:0] cmd_byte;
    } ps2kb_entry_t;

endpackage
`default_nettype wire

FILE: src/ps2kb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2kb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ps2kb_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: src/ps2_keyboard_command_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_keyboard_command_sequencer
// Host-side PS/2 keyboard command queue and reply handling.
// ----------------------------------------------------------------------------
// Each word goes through an accept and an execute cycle: the accept edge reads the head command from the
// command RAM, the next cycle (busy high) decodes it and updates the queue
// state, and the result appears for one cycle with result_valid in the cycle
// after that, when a new word may already be accepted. The execute cycle is
// needed because the command RAM has registered read data. Every accepted word
// gives exactly one result; result_valid is a strobe and is never held, so
// the receiver must take each result in the cycle it appears.
module ps2_keyboard_command_sequencer
    import ps2kb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire ps2kb_req_t cmd,
    output logic            result_valid,
    output ps2kb_res_t      result
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                 state_reg, state_next;
    ps2kb_req_t           req_reg;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [1:0]           sent_reg, sent_next;
    logic [1:0]           acks_reg, acks_next;
    logic                 hdone_reg, hdone_next;
    logic [7:0]           extra_reg, extra_next;
    ps2kb_res_t           res_reg, res_next;
    logic                 res_valid_reg;

    logic                 accept;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W:0]       tail_sum;
    logic [$bits(ps2kb_entry_t)-1:0] rd_data;
    ps2kb_entry_t         ent;
    ps2kb_entry_t         new_ent;
    logic                 waiting;
    logic                 do_remove;
    logic [1:0]           acks_inc;
    logic [CNT_W+3:0]     count_wide;

    assign busy   = (state_reg == ST_EXEC);
    assign accept = start && !busy;
    assign ent    = ps2kb_entry_t'(rd_data);

    assign new_ent.expects_extra = req_reg.expects_extra;
    assign new_ent.has_param     = req_reg.has_param;
    assign new_ent.param_byte    = req_reg.param_byte;
    assign new_ent.cmd_byte      = req_reg.cmd_byte;

    // tail = (head + count) mod depth, count below depth when written
    always_comb
    begin
        tail_sum = {1'b0, head_reg} + (IDX_W + 1)'(count_reg);
        if (tail_sum >= (IDX_W + 1)'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - (IDX_W + 1)'(QUEUE_DEPTH);
        end
        wr_addr = tail_sum[IDX_W-1:0];
    end

    ps2kb_ram #(
        .WIDTH ($bits(ps2kb_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (new_ent),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        sent_next  = sent_reg;
        acks_next  = acks_reg;
        hdone_next = hdone_reg;
        extra_next = extra_reg;
        res_next   = '0;
        wr_en      = 1'b0;
        do_remove  = 1'b0;
        waiting    = (count_reg != '0) && (sent_reg != 2'd0) && !hdone_reg;
        acks_inc   = (acks_reg == 2'd3) ? 2'd3 : acks_reg + 2'd1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (req_reg.req_type)
                    REQ_ENQUEUE:
                    begin
                        if (count_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            res_next.enqueue_rejected = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    REQ_RX:
                    begin
                        if (!waiting)
                        begin
                            res_next.key_valid = 1'b1;
                            res_next.key_byte  = req_reg.rx_byte;
                        end
                        else if (req_reg.rx_byte == BYTE_RESEND)
                        begin
                            sent_next = sent_reg - 2'd1;
                        end
                        else if (req_reg.rx_byte == BYTE_ACK)
                        begin
                            acks_next = acks_inc;
                            if (!ent.expects_extra)
                            begin
                                hdone_next = ent.has_param ? (acks_inc == 2'd2) : 1'b1;
                            end
                        end
                        else if (req_reg.rx_byte == BYTE_RESTART)
                        begin
                            sent_next  = 2'd0;
                            acks_next  = 2'd0;
                            hdone_next = 1'b0;
                        end
                        else if (req_reg.rx_byte == BYTE_ECHO && ent.cmd_byte == BYTE_ECHO)
                        begin
                            do_remove = 1'b1;
                        end
                        else
                        begin
                            extra_next = req_reg.rx_byte;
                            hdone_next = 1'b1;
                        end
                    end
                    REQ_TX:
                    begin
                        if (count_reg != '0)
                        begin
                            if (sent_reg == 2'd0 && acks_reg == 2'd0)
                            begin
                                res_next.tx_valid = 1'b1;
                                res_next.tx_byte  = ent.cmd_byte;
                                sent_next         = 2'd1;
                            end
                            else if (sent_reg == 2'd1 && acks_reg == 2'd1 && ent.has_param)
                            begin
                                res_next.tx_valid = 1'b1;
                                res_next.tx_byte  = ent.param_byte;
                                sent_next         = 2'd2;
                            end
                            do_remove = hdone_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (do_remove)
                begin
                    res_next.done_valid     = 1'b1;
                    res_next.done_status    = (ent.cmd_byte == CMD_RESET)
                                              && (extra_reg != SELF_TEST_PASS);
                    res_next.extra_response = extra_reg;
                    head_next  = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                 : head_reg + IDX_W'(1);
                    count_next = count_reg - CNT_W'(1);
                    sent_next  = 2'd0;
                    acks_next  = 2'd0;
                    hdone_next = 1'b0;
                end

                count_wide           = {4'b0, count_next};
                res_next.queue_count = count_wide[3:0];
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        count_wide = {4'b0, count_next};
        if (state_reg == ST_EXEC)
        begin
            res_next.queue_count = count_wide[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            sent_reg      <= 2'd0;
            acks_reg      <= 2'd0;
            hdone_reg     <= 1'b0;
            extra_reg     <= 8'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            sent_reg      <= sent_next;
            acks_reg      <= acks_next;
            hdone_reg     <= hdone_next;
            extra_reg     <= extra_next;
            res_valid_reg <= (state_reg == ST_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= cmd;
        end
        if (state_reg == ST_EXEC)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // result word follows an execute cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EXEC))
        else $error("result without execute cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // completion pops exactly one command
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.done_valid) |->
            (count_reg == CNT_W'($past(count_reg) - CNT_W'(1))))
        else $error("completion did not pop one command");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.enqueue_rejected) |-> (count_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("enqueue rejected with room left");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.tx_valid && !result.done_valid) |-> (sent_reg != 2'd0))
        else $error("byte sent without send progress");

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PS/2 keyboard command sequencer. Words go in
// through start/busy; every accepted word is run through a cycle-free model of
// the command queue and reply handling, and each strobed result is compared
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench
    import ps2kb_pkg::*;
;

    localparam int         DEPTH      = 8;
    localparam int         REQ_W      = $bits(ps2kb_req_t);
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         NUM_WORDS  = 1000;
    localparam int         HANG_LIMIT = 1000;

    // Queue model plus the store of predicted results.
    class seq_scoreboard;
        ps2kb_entry_t store [DEPTH];
        logic [2:0]   head = '0;
        logic [3:0]   count = '0;
        logic [1:0]   sent = '0;
        logic [1:0]   acks = '0;
        logic         head_done = 1'b0;
        logic [7:0]   captured = '0;
        ps2kb_res_t   pending_replies [$];
        int errors = 0;
        int n_checked = 0;
        int n_queued = 0;
        int n_rejected = 0;
        int n_completed = 0;
        int n_keys = 0;
        int n_tx = 0;

        function bit awaiting_reply();
            return count != 0 && sent != 0 && !head_done;
        endfunction

        function void retire_head(ps2kb_entry_t e, inout ps2kb_res_t r);
            r.done_valid     = 1'b1;
            r.done_status    = (e.cmd_byte == CMD_RESET && captured != SELF_TEST_PASS);
            r.extra_response = captured;
            head      = head + 3'd1;
            count     = count - 4'd1;
            sent      = '0;
            acks      = '0;
            head_done = 1'b0;
        endfunction

        function void note_word(ps2kb_req_t w);
            ps2kb_res_t   r;
            ps2kb_entry_t e;
            r = '0;
            e = store[head];
            case (w.req_type)
                REQ_ENQUEUE:
                    if (count >= DEPTH)
                    begin
                        r.enqueue_rejected = 1'b1;
                    end
                    else
                    begin
                        store[(int'(head) + int'(count)) % DEPTH] =
                            '{w.expects_extra, w.has_param, w.param_byte, w.cmd_byte};
                        count = count + 4'd1;
                    end
                REQ_RX:
                    if (!awaiting_reply())
                    begin
                        r.key_valid = 1'b1;
                        r.key_byte  = w.rx_byte;
                    end
                    else if (w.rx_byte == BYTE_RESEND)
                    begin
                        sent = sent - 2'd1;
                    end
                    else if (w.rx_byte == BYTE_ACK)
                    begin
                        if (acks != 2'd3)
                            acks = acks + 2'd1;
                        if (!e.expects_extra)
                            head_done = e.has_param ? (acks == 2'd2) : 1'b1;
                    end
                    else if (w.rx_byte == BYTE_RESTART)
                    begin
                        sent      = '0;
                        acks      = '0;
                        head_done = 1'b0;
                    end
                    else if (w.rx_byte == BYTE_ECHO && e.cmd_byte == BYTE_ECHO)
                    begin
                        retire_head(e, r);
                    end
                    else
                    begin
                        captured  = w.rx_byte;
                        head_done = 1'b1;
                    end
                REQ_TX:
                    if (count != 0)
                    begin
                        if (sent == 0 && acks == 0)
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = e.cmd_byte;
                            sent       = 2'd1;
                        end
                        else if (sent == 1 && acks == 1 && e.has_param)
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = e.param_byte;
                            sent       = 2'd2;
                        end
                        if (head_done)
                            retire_head(e, r);
                    end
                default: ;
            endcase
            r.queue_count = count;
            pending_replies.push_back(r);
        endfunction

        task report(string what);
            if (errors < 50)
                $display("ERROR @%0t: %s", $time, what);
            errors++;
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_reply(ps2kb_res_t got);
            ps2kb_res_t want;
            if (pending_replies.size() == 0)
            begin
                report("result with nothing expected");
                return;
            end
            want = pending_replies.pop_front();
            n_checked++;
            check_field("tx_valid", got.tx_valid, want.tx_valid);
            check_field("tx_byte", got.tx_byte, want.tx_byte);
            check_field("done_valid", got.done_valid, want.done_valid);
            check_field("done_status", got.done_status, want.done_status);
            check_field("extra_response", got.extra_response, want.extra_response);
            check_field("key_valid", got.key_valid, want.key_valid);
            check_field("key_byte", got.key_byte, want.key_byte);
            check_field("enqueue_rejected", got.enqueue_rejected, want.enqueue_rejected);
            check_field("queue_count", got.queue_count, want.queue_count);
            n_tx        += want.tx_valid;
            n_completed += want.done_valid;
            n_keys      += want.key_valid;
            n_rejected  += want.enqueue_rejected;
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    ps2kb_req_t cmd;
    logic       result_valid;
    ps2kb_res_t result;

    seq_scoreboard board;
    int            quiet_cycles;
    bit            allow_idle;

    ps2_keyboard_command_sequencer #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // accept/result monitor and hang watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                board.note_word(cmd);
                if (cmd.req_type == REQ_ENQUEUE)
                    board.n_queued++;
            end
            if (result_valid)
                board.check_reply(result);
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("timeout: no activity for %0d cycles", HANG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    task drive_word(ps2kb_req_t w);
        while (allow_idle && $urandom_range(99) < 35)
        begin
            start <= 1'b0;
            cmd   <= ps2kb_req_t'(REQ_W'($urandom));
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    function automatic ps2kb_req_t enq_word(logic [7:0] c, logic [7:0] p, logic hp, logic ex);
        ps2kb_req_t w;
        w               = '0;
        w.req_type      = REQ_ENQUEUE;
        w.cmd_byte      = c;
        w.param_byte    = p;
        w.has_param     = hp;
        w.expects_extra = ex;
        return w;
    endfunction

    function automatic ps2kb_req_t rx_word(logic [7:0] b);
        ps2kb_req_t w;
        w          = '0;
        w.req_type = REQ_RX;
        w.rx_byte  = b;
        return w;
    endfunction

    function automatic ps2kb_req_t tx_word();
        ps2kb_req_t w;
        w          = '0;
        w.req_type = REQ_TX;
        return w;
    endfunction

    // Mostly well-formed command traffic, steered by the model's head state.
    function automatic ps2kb_req_t next_random_word();
        ps2kb_req_t w;
        int         roll;
        int         enq_pct;
        w       = ps2kb_req_t'(REQ_W'($urandom));
        roll    = $urandom_range(99);
        enq_pct = (board.count < 3) ? 35 : ((board.count < 7) ? 15 : 8);
        if (roll < 5)
        begin
            w.req_type = REQ_UNUSED;
        end
        else if (roll < 5 + enq_pct)
        begin
            w.req_type = REQ_ENQUEUE;
            roll = $urandom_range(99);
            if (roll < 20)
                w.cmd_byte = BYTE_ECHO;
            else if (roll < 35)
                w.cmd_byte = CMD_RESET;
            w.expects_extra = ($urandom_range(99) < 30);
        end
        else if ($urandom_range(99) < 45)
        begin
            w.req_type = REQ_TX;
        end
        else
        begin
            w.req_type = REQ_RX;
            if (board.awaiting_reply())
            begin
                roll = $urandom_range(99);
                if (roll < 45)
                    w.rx_byte = BYTE_ACK;
                else if (roll < 55)
                    w.rx_byte = BYTE_RESEND;
                else if (roll < 60)
                    w.rx_byte = BYTE_RESTART;
                else if (roll < 70)
                    w.rx_byte = BYTE_ECHO;
                else if (roll < 80)
                    w.rx_byte = SELF_TEST_PASS;
                // resend after an ACK with only the command byte out wedges
                // the queue for good; that is saved for the end of the run
                if (w.rx_byte == BYTE_RESEND && board.sent == 1 && board.acks != 0)
                    w.rx_byte = BYTE_ACK;
            end
        end
        return w;
    endfunction

    initial
    begin
        int         n;
        ps2kb_req_t w;
        board        = new;
        quiet_cycles = 0;
        allow_idle   = 1'b1;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: unused code, key pass-through, transmit on an empty queue
        w          = '1;
        w.req_type = REQ_UNUSED;
        drive_word(w);
        drive_word(rx_word(BYTE_RESTART));
        drive_word(tx_word());
        // echo command completes on the echo byte
        drive_word(enq_word(BYTE_ECHO, 8'h00, 1'b0, 1'b0));
        drive_word(tx_word());
        drive_word(rx_word(BYTE_ECHO));
        // reset with self-test pass
        drive_word(enq_word(CMD_RESET, 8'hFF, 1'b0, 1'b1));
        drive_word(tx_word());
        drive_word(rx_word(BYTE_ACK));
        drive_word(rx_word(SELF_TEST_PASS));
        drive_word(tx_word());
        // command with data byte, resend of the command byte
        drive_word(enq_word(8'hED, 8'hFF, 1'b1, 1'b0));
        drive_word(tx_word());
        drive_word(rx_word(BYTE_RESEND));
        drive_word(tx_word());
        drive_word(rx_word(BYTE_ACK));
        drive_word(tx_word());
        drive_word(rx_word(BYTE_ACK));
        drive_word(tx_word());
        // reply byte lands before the data byte goes out
        drive_word(enq_word(8'h12, 8'h34, 1'b1, 1'b0));
        drive_word(tx_word());
        drive_word(rx_word(BYTE_ACK));
        drive_word(rx_word(8'h55));
        drive_word(tx_word());
        // reset completed by ACK alone judges the stale captured byte
        drive_word(enq_word(CMD_RESET, 8'h00, 1'b0, 1'b0));
        drive_word(tx_word());
        drive_word(rx_word(BYTE_ACK));
        drive_word(tx_word());

        n = 0;
        while (n < NUM_WORDS)
        begin
            allow_idle = (n < 300 || n >= 500);
            w = next_random_word();
            drive_word(w);
            if (w.req_type != REQ_UNUSED)
                n++;
        end
        allow_idle = 1'b1;

        // drain whatever is queued
        while (board.count != 0)
        begin
            if (board.awaiting_reply())
                drive_word(rx_word(8'h55));
            else
                drive_word(tx_word());
        end

        // resend with no byte pending: head stalls, replies become key bytes
        drive_word(enq_word(8'h20, 8'h21, 1'b1, 1'b0));
        drive_word(tx_word());
        drive_word(rx_word(BYTE_ACK));
        drive_word(rx_word(BYTE_RESEND));
        drive_word(tx_word());
        drive_word(rx_word(BYTE_RESTART));
        repeat (DEPTH + 1)
            drive_word(enq_word(8'($urandom), 8'($urandom), 1'b1, 1'b1));
        drive_word(tx_word());

        start <= 1'b0;
        while (board.pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("checked %0d results: %0d commands queued, %0d rejected as full,",
                 board.n_checked, board.n_queued, board.n_rejected);
        $display("%0d completed, %0d bytes sent, %0d key bytes passed, %0d errors",
                 board.n_completed, board.n_tx, board.n_keys, board.errors);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/ps2kb_pkg.sv
src/ps2kb_ram.sv
src/ps2_keyboard_command_sequencer.sv
tb/sv/testbench.sv
